FILE: hdl/r2p_pkg.sv
package r2p_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int ANG_PI_LOG   = 23;
  localparam int CORDIC_STEPS = 23;

  // Inputs enter the rotations scaled by 2^(60 - DATA_WIDTH), so the truncation
  // at every arithmetic shift lands on the same bits as the full 64-bit form
  localparam int GUARD   = 60 - DATA_WIDTH;
  localparam int XW      = DATA_WIDTH + GUARD + 2;
  localparam int ZW      = ANG_PI_LOG + 2;
  localparam int SW      = 2 * DATA_WIDTH;
  localparam int RW      = DATA_WIDTH + 3;
  localparam int NCELLS  = (CORDIC_STEPS > DATA_WIDTH) ? CORDIC_STEPS : DATA_WIDTH;
  localparam int CIDX_W  = $clog2(NCELLS);
  localparam int ATAN_IW = $clog2(CORDIC_STEPS);

  // Conversion of the internal angle (pi = 2^ANG_PI_LOG) to the output scale
  localparam int ANG_SH   = ANG_PI_LOG + 1 - DATA_WIDTH;
  localparam int ANG_RSH  = (ANG_SH > 0) ? ANG_SH : 0;
  localparam int ANG_LSH  = (ANG_SH < 0) ? -ANG_SH : 0;
  localparam int ANG_HALF = (1 << ANG_RSH) >> 1;
  localparam int AW       = ZW + 1 + ANG_LSH;

  localparam int FORM_W = 2;
  localparam logic [FORM_W-1:0] FORM_VECTOR    = 2'd0;
  localparam logic [FORM_W-1:0] FORM_ALGEBRAIC = 2'd1;
  localparam logic [FORM_W-1:0] FORM_POLAR     = 2'd2;

  localparam logic signed [ZW-1:0] Z_PI      = ZW'(64'sd1 << ANG_PI_LOG);
  localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(64'sd1 << (ANG_PI_LOG - 1));

  // atan(2^-i), pi = 2^23
  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050, 25'sd166669,
    25'sd83416,   25'sd41718,   25'sd20860,  25'sd10430,  25'sd5215,
    25'sd2608,    25'sd1304,    25'sd652,    25'sd326,    25'sd163,
    25'sd81,      25'sd41,      25'sd20,     25'sd10,     25'sd5,
    25'sd3,       25'sd1,       25'sd1
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         fixed;
    logic signed [XW-1:0]         x;
    logic signed [XW-1:0]         y;
    logic signed [ZW-1:0]         z;
    logic [SW-1:0]                s;
    logic [RW-1:0]                rem;
    logic [DATA_WIDTH-1:0]        q;
  } cell_data_t;

  typedef struct packed {
    logic signed [DATA_WIDTH:0]   first;
    logic signed [DATA_WIDTH-1:0] second;
  } result_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [CIDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    v = '0;
    if (int'(i) < CORDIC_STEPS) begin
      v = ATAN_TAB[i[ATAN_IW-1:0]];
    end
    return v;
  endfunction

endpackage

FILE: hdl/r2p_prep.sv
module r2p_prep (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  v_in,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] re_in,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] im_in,
  output logic                                  v_out,
  output r2p_pkg::cell_data_t                   d_out
);
  import r2p_pkg::*;

  cell_data_t            st0_r, st0_nxt, st1_r, st1_nxt, st2_r, st2_nxt;
  logic [DATA_WIDTH-1:0] ar_r, ar_nxt, ai_r, ai_nxt;
  logic [SW-1:0]         sqr_r, sqr_nxt, sqi_r, sqi_nxt;
  logic                  v0_r, v1_r, v2_r;
  logic signed [XW-1:0]  xe, ye;

  // Stage 0: fold into the right half plane, settle the axis cases
  always_comb begin
    xe = XW'(re_in) <<< GUARD;
    ye = XW'(im_in) <<< GUARD;
    st0_nxt       = '0;
    st0_nxt.re    = re_in;
    st0_nxt.im    = im_in;
    st0_nxt.fixed = (re_in == '0) || (im_in == '0);
    st0_nxt.x     = re_in[DATA_WIDTH-1] ? -xe : xe;
    st0_nxt.y     = re_in[DATA_WIDTH-1] ? -ye : ye;
    if (re_in == '0 && im_in == '0) begin
      st0_nxt.z = '0;
    end else if (re_in == '0) begin
      st0_nxt.z = (im_in > 0) ? Z_HALF_PI : -Z_HALF_PI;
    end else if (im_in == '0) begin
      st0_nxt.z = (re_in > 0) ? '0 : Z_PI;
    end else if (re_in[DATA_WIDTH-1]) begin
      st0_nxt.z = (im_in > 0) ? Z_PI : -Z_PI;
    end else begin
      st0_nxt.z = '0;
    end
    ar_nxt = re_in[DATA_WIDTH-1] ? DATA_WIDTH'(-re_in) : DATA_WIDTH'(re_in);
    ai_nxt = im_in[DATA_WIDTH-1] ? DATA_WIDTH'(-im_in) : DATA_WIDTH'(im_in);
  end

  // Stage 1: squares; stage 2: sum of squares
  always_comb begin
    st1_nxt  = st0_r;
    sqr_nxt  = SW'(ar_r) * SW'(ar_r);
    sqi_nxt  = SW'(ai_r) * SW'(ai_r);
    st2_nxt   = st1_r;
    st2_nxt.s = sqr_r + sqi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= v_in;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r <= st0_nxt;
      ar_r  <= ar_nxt;
      ai_r  <= ai_nxt;
      st1_r <= st1_nxt;
      sqr_r <= sqr_nxt;
      sqi_r <= sqi_nxt;
      st2_r <= st2_nxt;
    end
  end

  assign v_out = v2_r;
  assign d_out = st2_r;

endmodule

FILE: hdl/r2p_cell.sv
module r2p_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [r2p_pkg::CIDX_W-1:0]       idx,
  input  logic                             v_in,
  input  r2p_pkg::cell_data_t              d_in,
  output logic                             v_out,
  output r2p_pkg::cell_data_t              d_out
);
  import r2p_pkg::*;

  cell_data_t           d_r, d_nxt;
  logic                 v_r;
  logic signed [XW-1:0] xs, ys;
  logic [RW-1:0]        rem_sh, trial;

  always_comb begin
    d_nxt  = d_in;
    xs     = d_in.x >>> idx;
    ys     = d_in.y >>> idx;
    rem_sh = {d_in.rem[RW-3:0], d_in.s[SW-1 -: 2]};
    trial  = {1'b0, d_in.q, 2'b01};

    // One vectoring rotation; axis cases keep their angle
    if (int'(idx) < CORDIC_STEPS && !d_in.fixed) begin
      if (!d_in.y[XW-1] && d_in.y != '0) begin
        d_nxt.x = d_in.x + ys;
        d_nxt.y = d_in.y - xs;
        d_nxt.z = d_in.z + atan_step(idx);
      end else begin
        d_nxt.x = d_in.x - ys;
        d_nxt.y = d_in.y + xs;
        d_nxt.z = d_in.z - atan_step(idx);
      end
    end

    // One root digit: bring down two radicand bits, try the next bit
    if (int'(idx) < DATA_WIDTH) begin
      d_nxt.s = {d_in.s[SW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        d_nxt.rem = rem_sh - trial;
        d_nxt.q   = {d_in.q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        d_nxt.rem = rem_sh;
        d_nxt.q   = {d_in.q[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

FILE: hdl/r2p_out.sv
module r2p_out (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  v_in,
  input  r2p_pkg::cell_data_t                   d_in,
  input  logic [r2p_pkg::FORM_W-1:0]            form_i,
  output logic                                  en,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [r2p_pkg::DATA_WIDTH:0]   out_first_coord,
  output logic signed [r2p_pkg::DATA_WIDTH-1:0] out_second_coord
);
  import r2p_pkg::*;

  result_t               fin_res, out_r, out_nxt, skid_r, skid_nxt;
  logic                  out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic                  push, take;
  logic [DATA_WIDTH:0]   mag;
  logic signed [AW-1:0]  za, za_sh;

  // Round the root to nearest, scale the angle
  always_comb begin
    mag   = {1'b0, d_in.q} + (DATA_WIDTH+1)'(d_in.rem > RW'(d_in.q));
    za    = AW'(d_in.z) + AW'(ANG_HALF);
    za_sh = (za >>> ANG_RSH) <<< ANG_LSH;
    unique case (form_i) inside
      FORM_POLAR: begin
        fin_res.first  = mag;
        fin_res.second = za_sh[DATA_WIDTH-1:0];
      end
      FORM_VECTOR, FORM_ALGEBRAIC: begin
        fin_res.first  = (DATA_WIDTH+1)'(d_in.re);
        fin_res.second = d_in.im;
      end
      default: begin
        fin_res.first  = (DATA_WIDTH+1)'(d_in.re);
        fin_res.second = d_in.im;
      end
    endcase
  end

  assign en   = !skid_v_r;
  assign push = en && v_in;
  assign take = out_v_r && !out_stall;

  // Output register with one skid entry; the chain halts only when the skid is full
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = fin_res;
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = fin_res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_first_coord  = out_r.first;
  assign out_second_coord = out_r.second;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without an output request");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && take |=> out_v_r && !skid_v_r && out_r == $past(skid_r))
    else $error("skid entry not moved to output");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !take && !skid_v_r && v_in |=> skid_v_r && skid_r == $past(fin_res))
    else $error("request lost while output stalled");

endmodule

FILE: hdl/rect_to_polar_converter.sv
// Channel  Ports                                          Direction  Handshake
// in       in_real_part, in_imag_part                     input      in_valid / in_stall
// out      out_first_coord, out_second_coord              output     out_valid / out_stall
// cfg      cfg_data (coordinate form)                     input      cfg_valid / cfg_ready
//
// One request per clock unless in_stall; 3 prep stages, 23 CORDIC/root cells, then the output.
// Throughput is set by the cell chain, which advances every cycle unless the skid entry is full.
// in_stall is registered: it rises only when output and skid both hold a result.
// Reset (rst_n low, synchronous) empties the chain and sets the vector form.
// cfg_ready is always high; write only while no request is in flight.
module rect_to_polar_converter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] in_real_part,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] in_imag_part,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [r2p_pkg::DATA_WIDTH:0]   out_first_coord,
  output logic signed [r2p_pkg::DATA_WIDTH-1:0] out_second_coord,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [r2p_pkg::FORM_W-1:0]            cfg_data
);
  import r2p_pkg::*;

  logic [FORM_W-1:0] form_r, form_nxt;
  logic              en;
  cell_data_t        chain_d [NCELLS+1];
  logic              chain_v [NCELLS+1];

  assign cfg_ready = 1'b1;
  assign form_nxt  = cfg_valid ? cfg_data : form_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r <= FORM_VECTOR;
    end else begin
      form_r <= form_nxt;
    end
  end

  assign in_stall = !en;

  r2p_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (in_valid),
    .re_in (in_real_part),
    .im_in (in_imag_part),
    .v_out (chain_v[0]),
    .d_out (chain_d[0])
  );

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    r2p_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (CIDX_W'(g)),
      .v_in  (chain_v[g]),
      .d_in  (chain_d[g]),
      .v_out (chain_v[g+1]),
      .d_out (chain_d[g+1])
    );
  end

  r2p_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .v_in             (chain_v[NCELLS]),
    .d_in             (chain_d[NCELLS]),
    .form_i           (form_r),
    .en               (en),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_first_coord  (out_first_coord),
    .out_second_coord (out_second_coord)
  );

endmodule
